[design/lfc_pkg.sv]
// shared constants and types for the lru fingerprint cache
// no dependencies
`timescale 1ns / 1ps

package lfc_pkg;

  localparam int CAPACITY = 256;
  localparam int BUCKETS  = 256;
  localparam int KEY_W    = 64;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int PTR_W    = SLOT_W + 1;
  localparam int BKT_W    = $clog2(BUCKETS);
  localparam int CNT_W    = PTR_W;

  // empty head or end of chain
  localparam logic [PTR_W-1:0] NO_SLOT = PTR_W'(CAPACITY);

  typedef struct packed {
    logic             en;
    logic [BKT_W-1:0] addr;
    logic [PTR_W-1:0] data;
  } head_wr_t;

endpackage

[design/lru_fingerprint_cache.sv]
// lru fingerprint cache top level: lookup, eviction and recency update
// depends on lfc_pkg and lfc_bucket_table
`timescale 1ns / 1ps
//
// channel   direction  handshake                  payload
// key       in         key_valid / key_stall      block_key
// result    out        result_valid / result_stall hit, evicted, evicted_key, occupancy
// cfg       in         cfg_wr_en                  cfg_wr_data (capacity)
//
// one item at a time; a hit walks the bucket chain to the key and then moves it to
// the newest end of the recency list unless it is already newest; a miss walks the
// whole chain and fills a free slot, or, at capacity, first unlinks the oldest key
// from its own bucket chain and reuses its slot
// the input accepts again in the same cycle that the result is set
// reset clears the bucket valid bits at once, no clearing pass
// a waiting result holds the block in its final state until it is taken

module lru_fingerprint_cache
  import lfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             key_valid,
  output logic             key_stall,
  input  logic [KEY_W-1:0] block_key,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             hit,
  output logic             evicted,
  output logic [KEY_W-1:0] evicted_key,
  output logic [CNT_W-1:0] occupancy,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_HEAD   = 4'd1;
  localparam logic [3:0] S_CMP    = 4'd2;
  localparam logic [3:0] S_H_RD   = 4'd3;
  localparam logic [3:0] S_H_WAIT = 4'd4;
  localparam logic [3:0] S_H_LINK = 4'd5;
  localparam logic [3:0] S_E_RD   = 4'd6;
  localparam logic [3:0] S_E_KEY  = 4'd7;
  localparam logic [3:0] S_E_HEAD = 4'd8;
  localparam logic [3:0] S_E_WALK = 4'd9;
  localparam logic [3:0] S_INS    = 4'd10;
  localparam logic [3:0] S_INS2   = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  logic [3:0] state;

  logic [KEY_W-1:0]  keys_mem  [CAPACITY];
  logic [PTR_W-1:0]  chain_mem [CAPACITY];
  logic [SLOT_W-1:0] rnext_mem [CAPACITY];
  logic [SLOT_W-1:0] rprev_mem [CAPACITY];
  logic [KEY_W-1:0]  keys_rd;
  logic [PTR_W-1:0]  chain_rd;
  logic [SLOT_W-1:0] rnext_rd;
  logic [SLOT_W-1:0] rprev_rd;

  logic [KEY_W-1:0]  key;
  logic [PTR_W-1:0]  cur;
  logic [SLOT_W-1:0] slot;
  logic [KEY_W-1:0]  evkey;
  logic [PTR_W-1:0]  sch;
  logic              list_empty;
  logic              is_hit;
  logic              is_evict;
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] oldest;
  logic [SLOT_W-1:0] newest;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  limit;

  logic [PTR_W-1:0]  head_slot;
  logic [BKT_W-1:0]  head_rd_addr;
  head_wr_t          head_wr;

  logic [SLOT_W-1:0] kc_addr;
  logic [SLOT_W-1:0] rl_addr;
  logic              chain_we;
  logic [SLOT_W-1:0] chain_wa;
  logic [PTR_W-1:0]  chain_wd;
  logic              rnext_we;
  logic [SLOT_W-1:0] rnext_wa;
  logic [SLOT_W-1:0] rnext_wd;
  logic              rprev_we;
  logic [SLOT_W-1:0] rprev_wa;
  logic [SLOT_W-1:0] rprev_wd;
  logic              keys_we;
  logic              key_match;
  logic              ev_head_match;
  logic              walk_match;

  lfc_bucket_table u_buckets (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (head_rd_addr),
    .wr      (head_wr),
    .rd_slot (head_slot)
  );

  assign key_stall = (state != S_IDLE);

  always_comb begin
    if (cap == '0) begin
      limit = CNT_W'(1);
    end else if (cap > CNT_W'(CAPACITY)) begin
      limit = CNT_W'(CAPACITY);
    end else begin
      limit = cap;
    end
  end

  assign key_match     = (keys_rd == key);
  assign ev_head_match = (head_slot == {1'b0, slot});
  assign walk_match    = (chain_rd == {1'b0, slot});

  // read addresses and write requests for every memory
  always_comb begin
    unique case (state)
      S_IDLE:  head_rd_addr = block_key[BKT_W-1:0];
      S_E_KEY: head_rd_addr = keys_rd[BKT_W-1:0];
      default: head_rd_addr = key[BKT_W-1:0];
    endcase

    unique case (state) inside
      S_HEAD, S_E_HEAD: kc_addr = head_slot[SLOT_W-1:0];
      S_CMP, S_E_WALK:  kc_addr = chain_rd[SLOT_W-1:0];
      S_E_RD:           kc_addr = oldest;
      default:          kc_addr = slot;
    endcase

    rl_addr = (state == S_E_RD) ? oldest : slot;

    head_wr  = '0;
    chain_we = 1'b0;
    chain_wa = slot;
    chain_wd = head_slot;
    rnext_we = 1'b0;
    rnext_wa = newest;
    rnext_wd = slot;
    rprev_we = 1'b0;
    rprev_wa = slot;
    rprev_wd = newest;
    keys_we  = 1'b0;

    unique case (state)
      S_H_WAIT: begin
        if (slot != oldest) begin
          rnext_we = 1'b1;
          rnext_wa = rprev_rd;
          rnext_wd = rnext_rd;
          rprev_we = 1'b1;
          rprev_wa = rnext_rd;
          rprev_wd = rprev_rd;
        end
      end
      S_H_LINK: begin
        rnext_we = 1'b1;
        rprev_we = 1'b1;
      end
      S_E_HEAD: begin
        if (ev_head_match) begin
          head_wr.en   = 1'b1;
          head_wr.addr = evkey[BKT_W-1:0];
          head_wr.data = sch;
        end
      end
      S_E_WALK: begin
        if (walk_match) begin
          chain_we = 1'b1;
          chain_wa = cur[SLOT_W-1:0];
          chain_wd = sch;
        end
      end
      S_INS2: begin
        keys_we      = 1'b1;
        chain_we     = 1'b1;
        head_wr.en   = 1'b1;
        head_wr.addr = key[BKT_W-1:0];
        head_wr.data = {1'b0, slot};
        rnext_we     = !list_empty;
        rprev_we     = !list_empty;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (keys_we) begin
      keys_mem[slot] <= key;
    end
    if (chain_we) begin
      chain_mem[chain_wa] <= chain_wd;
    end
    if (rnext_we) begin
      rnext_mem[rnext_wa] <= rnext_wd;
    end
    if (rprev_we) begin
      rprev_mem[rprev_wa] <= rprev_wd;
    end
    keys_rd  <= keys_mem[kc_addr];
    chain_rd <= chain_mem[kc_addr];
    rnext_rd <= rnext_mem[rl_addr];
    rprev_rd <= rprev_mem[rl_addr];
  end

  // payload registers of the item in flight
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        key <= block_key;
      end
      S_HEAD: begin
        cur <= head_slot;
      end
      S_CMP: begin
        if (cur != NO_SLOT && key_match) begin
          slot <= cur[SLOT_W-1:0];
        end else if ((cur == NO_SLOT || chain_rd == NO_SLOT) && count < limit) begin
          slot       <= count[SLOT_W-1:0];
          list_empty <= (count == '0);
        end
        cur <= chain_rd;
      end
      S_E_RD: begin
        slot <= oldest;
      end
      S_E_KEY: begin
        evkey      <= keys_rd;
        sch        <= chain_rd;
        list_empty <= (count <= CNT_W'(1));
      end
      S_E_HEAD: begin
        cur <= head_slot;
      end
      S_E_WALK: begin
        cur <= chain_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      oldest       <= '0;
      newest       <= '0;
      cap          <= CNT_W'(CAPACITY);
      is_hit       <= 1'b0;
      is_evict     <= 1'b0;
      result_valid <= 1'b0;
      hit          <= 1'b0;
      evicted      <= 1'b0;
      evicted_key  <= '0;
      occupancy    <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
      // in the final state a taken result is replaced below
      if (result_valid && !result_stall && state != S_FIN) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (key_valid) begin
            is_hit   <= 1'b0;
            is_evict <= 1'b0;
            state    <= S_HEAD;
          end
        end
        S_HEAD: begin
          state <= (head_slot == NO_SLOT) ? S_CMP : S_CMP;
        end
        S_CMP: begin
          // cur holds the slot whose key and link are on the read ports
          if (cur != NO_SLOT && key_match) begin
            is_hit <= 1'b1;
            state  <= (cur[SLOT_W-1:0] == newest) ? S_FIN : S_H_RD;
          end else if (cur == NO_SLOT || chain_rd == NO_SLOT) begin
            if (count >= limit) begin
              is_evict <= 1'b1;
              state    <= S_E_RD;
            end else begin
              count <= count + CNT_W'(1);
              state <= S_INS;
            end
          end
        end
        S_H_RD: state <= S_H_WAIT;
        S_H_WAIT: begin
          if (slot == oldest) begin
            oldest <= rnext_rd;
          end
          state <= S_H_LINK;
        end
        S_H_LINK: begin
          newest <= slot;
          state  <= S_FIN;
        end
        S_E_RD: state <= S_E_KEY;
        S_E_KEY: begin
          if (count > CNT_W'(1)) begin
            oldest <= rnext_rd;
          end
          state <= S_E_HEAD;
        end
        S_E_HEAD: begin
          state <= ev_head_match ? S_INS : S_E_WALK;
        end
        S_E_WALK: begin
          if (walk_match) begin
            state <= S_INS;
          end
        end
        S_INS: state <= S_INS2;
        S_INS2: begin
          if (list_empty) begin
            oldest <= slot;
          end
          newest <= slot;
          state  <= S_FIN;
        end
        S_FIN: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            hit          <= is_hit;
            evicted      <= is_evict;
            evicted_key  <= is_evict ? evkey : '0;
            occupancy    <= count;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    key_valid && !key_stall |=> state == S_HEAD)
    else $error("accepted item did not start lookup");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(hit && evicted))
    else $error("hit and eviction in one item");

  a_no_evict_zero_key: assert property (@(posedge clk) disable iff (rst)
    result_valid && !evicted |-> evicted_key == '0)
    else $error("evicted key set without eviction");

  a_occupancy_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> occupancy != '0)
    else $error("empty cache after an item");
`endif

endmodule

[design/lfc_bucket_table.sv]
// bucket head table: synchronous memory with per-bucket valid bits
// depends on lfc_pkg
`timescale 1ns / 1ps

module lfc_bucket_table
  import lfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [BKT_W-1:0] rd_addr,
  input  head_wr_t         wr,
  output logic [PTR_W-1:0] rd_slot
);

  logic [PTR_W-1:0] heads [BUCKETS];
  logic [BUCKETS-1:0] head_valid;
  logic [PTR_W-1:0] rd_data;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      heads[wr.addr] <= wr.data;
    end
    rd_data <= heads[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (wr.en) begin
        head_valid[wr.addr] <= 1'b1;
      end
      rd_valid <= head_valid[rd_addr];
    end
  end

  // never-written bucket reads as empty
  assign rd_slot = rd_valid ? rd_data : NO_SLOT;

endmodule
